// File: design/l2lf_pkg.sv
// Shared types, constants and beat layouts for the learning forwarder.
package l2lf_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 1024;

	localparam int unsigned MAC_W    = 48;
	localparam int unsigned PORT_W   = 16;
	localparam int unsigned S_DATA_W = 176;
	localparam int unsigned M_DATA_W = 24;
	localparam int unsigned GROUP_BIT = 40;

	localparam logic [15:0] LLDP_TYPE  = 16'h88CC;
	localparam logic [15:0] FLOOD_PORT = 16'hFFFB;
	localparam logic [7:0]  TCP_PROTO  = 8'd6;

	localparam logic [15:0] L4_ISCSI   = 16'd3260;
	localparam logic [15:0] L4_BENCH   = 16'd5001;
	localparam logic [15:0] L4_SIP     = 16'd5060;
	localparam logic [15:0] L4_X11_A   = 16'd6000;
	localparam logic [15:0] L4_X11_B   = 16'd6002;

	typedef enum logic [1:0] {
		ACT_OUTPUT = 2'd0,
		ACT_QUEUE0 = 2'd1,
		ACT_QUEUE1 = 2'd2
	} act_t;

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic [15:0] ingress_port;
		logic [47:0] source_mac;
		logic [47:0] dest_mac;
		logic [15:0] ether_type;
		logic [7:0]  ip_protocol;
		logic [15:0] src_l4_port;
		logic [15:0] dst_l4_port;
		logic        unbuffered;
		logic        whole_packet;
	} item_t;

	typedef struct packed {
		logic        dropped;
		logic        install_flow;
		act_t        flow_action;
		logic [15:0] egress_port;
		logic        send_packet;
		logic        out_from_buffer;
	} result_t;

	// One table entry as stored in the RAM.
	typedef struct packed {
		logic        valid;
		logic [47:0] mac;
		logic [15:0] port;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// File: design/l2lf_ram.sv
// Generic single-clock RAM, one write port, one registered read port.
module l2lf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/l2lf_index.sv
// Table index hash: XOR of index-width slices of a MAC, folded into range.
module l2lf_index #(
	parameter int unsigned TABLE_ENTRIES = l2lf_pkg::TABLE_ENTRIES_DEF
) (
	input  logic [l2lf_pkg::MAC_W-1:0]       mac,
	output logic [$clog2(TABLE_ENTRIES)-1:0] idx
);

	import l2lf_pkg::*;

	localparam int unsigned W   = $clog2(TABLE_ENTRIES);
	localparam int unsigned NSL = (MAC_W + W - 1) / W;
	localparam logic [W:0]  ENT = (W+1)'(TABLE_ENTRIES);

	logic [NSL*W-1:0] mac_ext;
	logic [W-1:0]     acc;
	logic [W:0]       acc_ext;
	logic [W:0]       acc_sub;

	assign mac_ext = (NSL*W)'(mac);

	always_comb begin
		acc = '0;
		for (int i = 0; i < NSL; i++) begin
			acc = acc ^ mac_ext[i*W +: W];
		end
	end

	// Fold once: the hash stays below twice the table size.
	assign acc_ext = {1'b0, acc};
	assign acc_sub = acc_ext - ENT;
	assign idx     = (acc_ext >= ENT) ? acc_sub[W-1:0] : acc;

endmodule

// File: design/l2lf_decide.sv
// Forwarding decision: drop, flow class, packet-out and egress selection.
module l2lf_decide (
	input  l2lf_pkg::item_t   item,
	input  logic              hit,
	input  logic [15:0]       learned_port,
	input  logic              flow_en,
	output l2lf_pkg::result_t res
);

	import l2lf_pkg::*;

	logic is_lldp;
	logic install;
	logic tcp_iscsi;
	logic qos_port;
	logic no_flow_path;

	assign is_lldp   = (item.ether_type == LLDP_TYPE);
	assign install   = flow_en && hit;
	assign tcp_iscsi = (item.ip_protocol == TCP_PROTO) &&
		((item.src_l4_port == L4_ISCSI) || (item.dst_l4_port == L4_ISCSI));
	assign qos_port  =
		(item.src_l4_port == L4_BENCH) || (item.dst_l4_port == L4_BENCH) ||
		(item.src_l4_port == L4_SIP)   || (item.dst_l4_port == L4_SIP)   ||
		(item.src_l4_port == L4_X11_A) || (item.dst_l4_port == L4_X11_A) ||
		(item.src_l4_port == L4_X11_B) || (item.dst_l4_port == L4_X11_B);
	assign no_flow_path = !flow_en || !hit || item.unbuffered;

	always_comb begin
		res = '0;
		if (is_lldp) begin
			res.dropped = 1'b1;
		end else begin
			res.install_flow = install;
			res.egress_port  = hit ? learned_port : FLOOD_PORT;
			if (install) begin
				priority if (tcp_iscsi) begin
					res.flow_action = ACT_QUEUE1;
				end else if (qos_port) begin
					res.flow_action = ACT_QUEUE0;
				end else begin
					res.flow_action = ACT_OUTPUT;
				end
			end
			// Truncated unbuffered packets get no packet-out.
			if (no_flow_path) begin
				if (!item.unbuffered) begin
					res.send_packet     = 1'b1;
					res.out_from_buffer = 1'b1;
				end else if (item.whole_packet) begin
					res.send_packet = 1'b1;
				end
			end
		end
	end

endmodule

// File: design/l2_learning_forwarder_qos_core.sv
// Top level of the L2 learning forwarder with QoS flow classification.
//
//  channel | signals                   | beat content
//  --------+---------------------------+-------------------------------------
//  s       | s_tvalid s_tready s_tdata | one packet header
//  m       | m_tvalid m_tready m_tdata | one forwarding decision
//  cfg     | cfg_valid cfg_ready       | flow_setup_enable in cfg_data
//
// One header per cycle while not clearing and not stalled: the accepting edge
// launches the table read and the decision is loaded into the output register
// when the pipeline advances; a lookup of the index that the same header learns
// takes the new entry around the RAM. After reset a clearing pass writes every
// entry with s_tready low. While a valid output beat waits on m_tready, it and
// any header in flight are held, and s_tready drops while one is in flight.
module l2_learning_forwarder_qos_core #(
	parameter int unsigned TABLE_ENTRIES = l2lf_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// ingress_port[15:0] source_mac[63:16] dest_mac[111:64] ether_type[127:112]
	// ip_protocol[135:128] src_l4_port[151:136] dst_l4_port[167:152]
	// unbuffered[168] whole_packet[169], zero fill above
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [l2lf_pkg::S_DATA_W-1:0] s_tdata,
	// dropped[0] install_flow[1] flow_action[3:2] egress_port[19:4]
	// send_packet[20] out_from_buffer[21], zero fill above
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [l2lf_pkg::M_DATA_W-1:0] m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_data
);

	import l2lf_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_ENTRIES);

	state_t state_q, state_d;
	logic [AW-1:0] clr_q;
	logic          clr_last;
	logic          clearing;

	logic    flow_en_q;
	item_t   item_in;
	logic    accept;
	logic    adv;
	logic    learn;
	logic [AW-1:0] idx_src;
	logic [AW-1:0] idx_dst;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	entry_t        ram_wdata;
	entry_t        ram_rdata;

	logic    valid_s1;
	item_t   item_s1;
	logic    fwd_s1;
	entry_t  entry_s1;
	logic    hit_s1;
	result_t res_s1;

	logic    out_valid_q;
	result_t res_q;

	// Unpack the header beat.
	assign item_in.ingress_port = s_tdata[15:0];
	assign item_in.source_mac   = s_tdata[63:16];
	assign item_in.dest_mac     = s_tdata[111:64];
	assign item_in.ether_type   = s_tdata[127:112];
	assign item_in.ip_protocol  = s_tdata[135:128];
	assign item_in.src_l4_port  = s_tdata[151:136];
	assign item_in.dst_l4_port  = s_tdata[167:152];
	assign item_in.unbuffered   = s_tdata[168];
	assign item_in.whole_packet = s_tdata[169];

	// Clearing sequencer.
	assign clr_last = (clr_q == AW'(TABLE_ENTRIES - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_last) state_d = ST_RUN;
			ST_RUN:   state_d = ST_RUN;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		unique case (state_q)
			ST_CLEAR: clearing = 1'b1;
			ST_RUN:   clearing = 1'b0;
			default:  clearing = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clearing && !clr_last) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	// Configuration register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flow_en_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			flow_en_q <= cfg_data;
		end
	end

	// Handshake and pipeline advance.
	assign adv      = !out_valid_q || m_tready;
	assign s_tready = !clearing && (!valid_s1 || adv);
	assign accept   = s_tvalid && s_tready;

	l2lf_index #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_idx_src (
		.mac (item_in.source_mac),
		.idx (idx_src)
	);

	l2lf_index #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_idx_dst (
		.mac (item_in.dest_mac),
		.idx (idx_dst)
	);

	// Learn unicast sources of non-LLDP frames.
	assign learn = accept && (item_in.ether_type != LLDP_TYPE) &&
		!item_in.source_mac[GROUP_BIT];

	always_comb begin
		ram_we    = clearing || learn;
		ram_waddr = clearing ? clr_q : idx_src;
		ram_wdata = '0;
		if (!clearing) begin
			ram_wdata.valid = 1'b1;
			ram_wdata.mac   = item_in.source_mac;
			ram_wdata.port  = item_in.ingress_port;
		end
	end

	l2lf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (idx_dst),
		.rdata (ram_rdata)
	);

	// Stage 1: header waits for the table read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
			fwd_s1  <= learn && (idx_src == idx_dst);
		end
	end

	// Take the entry just learned when the lookup lands on the same index.
	always_comb begin
		entry_s1 = ram_rdata;
		if (fwd_s1) begin
			entry_s1.valid = 1'b1;
			entry_s1.mac   = item_s1.source_mac;
			entry_s1.port  = item_s1.ingress_port;
		end
	end

	assign hit_s1 = !item_s1.dest_mac[GROUP_BIT] && entry_s1.valid &&
		(entry_s1.mac == item_s1.dest_mac);

	l2lf_decide u_decide (
		.item         (item_s1),
		.hit          (hit_s1),
		.learned_port (entry_s1.port),
		.flow_en      (flow_en_q),
		.res          (res_s1)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			res_q <= res_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00,
		res_q.out_from_buffer,
		res_q.send_packet,
		res_q.egress_port,
		res_q.flow_action,
		res_q.install_flow,
		res_q.dropped};

endmodule
